>>> rtl/l2p_pkg.sv
package l2p_pkg;

  localparam int unsigned CHIPS_ALONG_Z = 1;

  localparam int unsigned DIV_QW = 13;
  localparam int unsigned DIV_NW = 34;
  localparam int unsigned DIV_DW = 21;
  localparam int unsigned DIV_STAGES = DIV_QW + 1;

  localparam int unsigned CFG_DW = 27;

  typedef enum logic [2:0] {
    REG_PITCH_X       = 3'd0,
    REG_PITCH_Z       = 3'd1,
    REG_PITCH_Z_FIRST = 3'd2,
    REG_CHIP_LENGTH_Z = 3'd3,
    REG_COLS_PER_CHIP = 3'd4,
    REG_NUM_ROWS      = 3'd5,
    REG_SHIFT_X       = 3'd6,
    REG_SHIFT_Z       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0]        pitch_x;
    logic [19:0]        pitch_z;
    logic [19:0]        pitch_z_first;
    logic [26:0]        chip_length_z;
    logic [12:0]        cols_per_chip;
    logic [12:0]        num_rows;
    logic signed [24:0] shift_x;
    logic signed [24:0] shift_z;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       in_area;
    logic       col_past_first;
    logic [3:0] chip;
  } side_t;

endpackage

>>> rtl/l2p_cfg.sv
module l2p_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [l2p_pkg::CFG_DW-1:0]    cfg_data_i,
  output l2p_pkg::cfg_t                 cfg_o
);

  l2p_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (l2p_pkg::cfg_reg_e'(cfg_index_i))
        l2p_pkg::REG_PITCH_X:       cfg_d.pitch_x       = cfg_data_i[19:0];
        l2p_pkg::REG_PITCH_Z:       cfg_d.pitch_z       = cfg_data_i[19:0];
        l2p_pkg::REG_PITCH_Z_FIRST: cfg_d.pitch_z_first = cfg_data_i[19:0];
        l2p_pkg::REG_CHIP_LENGTH_Z: cfg_d.chip_length_z = cfg_data_i[26:0];
        l2p_pkg::REG_COLS_PER_CHIP: cfg_d.cols_per_chip = cfg_data_i[12:0];
        l2p_pkg::REG_NUM_ROWS:      cfg_d.num_rows      = cfg_data_i[12:0];
        l2p_pkg::REG_SHIFT_X:       cfg_d.shift_x       = $signed(cfg_data_i[24:0]);
        l2p_pkg::REG_SHIFT_Z:       cfg_d.shift_z       = $signed(cfg_data_i[24:0]);
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_x       <= 20'd29240;
      cfg_q.pitch_z       <= 20'd26880;
      cfg_q.pitch_z_first <= 20'd26880;
      cfg_q.chip_length_z <= 27'd27525120;
      cfg_q.cols_per_chip <= 13'd1024;
      cfg_q.num_rows      <= 13'd512;
      cfg_q.shift_x       <= '0;
      cfg_q.shift_z       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/l2p_div.sv
module l2p_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [l2p_pkg::DIV_NW-1:0]    dividend_i,
  input  logic [l2p_pkg::DIV_DW-1:0]    divisor_i,
  output logic [l2p_pkg::DIV_QW-1:0]    quotient_o
);

  localparam int unsigned NW = l2p_pkg::DIV_NW;
  localparam int unsigned QW = l2p_pkg::DIV_QW;
  localparam int unsigned NS = l2p_pkg::DIV_STAGES;

  logic [NW-1:0] rem_q [NS];
  logic [QW-1:0] quo_q [NS];
  logic          sat_q [NS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= dividend_i;
      quo_q[0] <= '0;
      sat_q[0] <= {1'b0, dividend_i} >= ((NW+1)'(divisor_i) << QW);
    end
  end

  for (genvar i = 1; i < NS; i++) begin : g_step
    logic [NW:0] shifted;
    logic        take;
    assign shifted = (NW+1)'(divisor_i) << (QW - i);
    assign take = {1'b0, rem_q[i-1]} >= shifted;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= take ? NW'({1'b0, rem_q[i-1]} - shifted) : rem_q[i-1];
        quo_q[i] <= quo_q[i-1] | (take ? (QW'(1) << (QW - i)) : '0);
        sat_q[i] <= sat_q[i-1];
      end
    end
  end

  assign quotient_o = sat_q[NS-1] ? '1 : quo_q[NS-1];

endmodule

>>> rtl/local_to_pixel_index_top.sv
// Maps a hit position in sensor-local coordinates (nm, centre origin) to a
// pixel row, a global column and a chip index.
// Input channel: in_valid_i/in_ready_o with pos_x_i and pos_z_i. Output
// channel: out_valid_o/out_ready_i with hit_valid_o, pixel_row_o,
// pixel_col_o and chip_index_o; one result for every request.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// it is always ready and must be written only while no request is in flight.
// Throughput is one request per cycle unless the receiver stalls; the two
// pipelined restoring dividers of 14 stages each (row and column) set the
// depth; stage one tests overflow, each later stage yields one quotient bit.
// When the receiver stalls the whole pipeline holds, so in_ready_o follows
// out_ready_i whenever a result is waiting. Reset empties the pipeline and
// loads the default geometry into the configuration registers.
module local_to_pixel_index_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [2:0]                 cfg_index_i,
  input  logic [l2p_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [27:0]         pos_x_i,
  input  logic signed [27:0]         pos_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_valid_o,
  output logic [11:0]                pixel_row_o,
  output logic [15:0]                pixel_col_o,
  output logic [3:0]                 chip_index_o
);

  localparam int unsigned NS = l2p_pkg::DIV_STAGES;

  l2p_pkg::cfg_t cfg;
  logic          en;

  l2p_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic [19:0] px_nz, pz_nz, pf_nz;
  logic [26:0] cl_nz;
  logic [12:0] cpc_nz;
  logic [27:0] cl2;
  logic [20:0] px2, pz2, pf2;

  assign px_nz  = (cfg.pitch_x == '0) ? 20'd1 : cfg.pitch_x;
  assign pz_nz  = (cfg.pitch_z == '0) ? 20'd1 : cfg.pitch_z;
  assign pf_nz  = (cfg.pitch_z_first == '0) ? 20'd1 : cfg.pitch_z_first;
  assign cl_nz  = (cfg.chip_length_z == '0) ? 27'd1 : cfg.chip_length_z;
  assign cpc_nz = (cfg.cols_per_chip == '0) ? 13'd1 : cfg.cols_per_chip;
  assign cl2 = {cl_nz, 1'b0};
  assign px2 = {px_nz, 1'b0};
  assign pz2 = {pz_nz, 1'b0};
  assign pf2 = {pf_nz, 1'b0};

  logic out_valid_q;
  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: capture and active width along x.
  logic               v1_q;
  logic signed [27:0] px1_q, pz1_q;
  logic [32:0]        dx1_q, dx1_d;
  assign dx1_d = cfg.num_rows * px_nz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= pos_x_i;
      pz1_q <= pos_z_i;
      dx1_q <= dx1_d;
    end
  end

  // Stage 2: doubled corner coordinates and the range check.
  logic [31:0]        dz;
  logic signed [34:0] x2, z2, x2_lim, z2_lim;
  logic               in_area_d;
  logic               v2_q, in2_q;
  logic [33:0]        x2_2q;
  logic [32:0]        z2_2q;

  assign dz = 32'(l2p_pkg::CHIPS_ALONG_Z) * 32'(cl_nz);
  assign x2 = $signed({{6{px1_q[27]}}, px1_q, 1'b0}) + $signed({2'b0, dx1_q})
            + $signed({{9{cfg.shift_x[24]}}, cfg.shift_x, 1'b0});
  assign z2 = $signed({{6{pz1_q[27]}}, pz1_q, 1'b0}) + $signed({3'b0, dz})
            + $signed({{9{cfg.shift_z[24]}}, cfg.shift_z, 1'b0});
  assign x2_lim = $signed({1'b0, dx1_q, 1'b0});
  assign z2_lim = $signed({2'b0, dz, 1'b0});
  assign in_area_d = !x2[34] && (x2 <= x2_lim) && !z2[34] && (z2 <= z2_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in2_q <= in_area_d;
      x2_2q <= x2[33:0];
      z2_2q <= z2[32:0];
    end
  end

  // Stage 3: chip index.
  logic [3:0]  chip_d;
  logic        v3_q, in3_q;
  logic [33:0] x2_3q;
  logic [32:0] z2_3q;
  logic [3:0]  chip3_q;

  always_comb begin
    chip_d = '0;
    for (int k = 1; k < l2p_pkg::CHIPS_ALONG_Z; k++) begin
      if (z2_2q >= 33'(k) * 33'(cl2)) begin
        chip_d = 4'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in3_q   <= in2_q;
      x2_3q   <= x2_2q;
      z2_3q   <= z2_2q;
      chip3_q <= chip_d;
    end
  end

  // Stage 4: remainder inside the chip.
  logic        v4_q, in4_q;
  logic [33:0] x2_4q;
  logic [27:0] r2_4q;
  logic [3:0]  chip4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in4_q   <= in3_q;
      x2_4q   <= x2_3q;
      r2_4q   <= 28'(z2_3q - 33'(chip3_q) * 33'(cl2));
      chip4_q <= chip3_q;
    end
  end

  // Stage 5: offset past the first column.
  l2p_pkg::side_t side_q [NS+1];
  logic [33:0]    x2_5q;
  logic [27:0]    d_5q;
  logic           past_first;
  assign past_first = r2_4q > 28'(pf2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) begin
        side_q[i] <= '0;
      end
    end else if (en) begin
      side_q[0].valid          <= v4_q;
      side_q[0].in_area        <= in4_q;
      side_q[0].col_past_first <= past_first;
      side_q[0].chip           <= chip4_q;
      for (int i = 1; i <= NS; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_5q <= x2_4q;
      d_5q  <= r2_4q - 28'(pf2);
    end
  end

  logic [l2p_pkg::DIV_QW-1:0] q_row, q_col;

  l2p_div u_div_row (
    .clk_i     (clk_i),
    .en_i      (en),
    .dividend_i(x2_5q),
    .divisor_i (px2),
    .quotient_o(q_row)
  );

  l2p_div u_div_col (
    .clk_i     (clk_i),
    .en_i      (en),
    .dividend_i({6'b0, d_5q}),
    .divisor_i (pz2),
    .quotient_o(q_col)
  );

  // Stage 6: clamps and chip base column.
  l2p_pkg::side_t s_div;
  logic [12:0]    nr_m1, cpc_m1, row_c, col_c;
  logic [13:0]    col_raw;
  logic [11:0]    row6_q;
  logic [12:0]    col6_q;
  logic [16:0]    base6_q;
  logic           v6_q, in6_q;
  logic [3:0]     chip6_q;

  assign s_div  = side_q[NS];
  assign nr_m1  = cfg.num_rows - 13'd1;
  assign cpc_m1 = cpc_nz - 13'd1;
  assign row_c  = (cfg.num_rows == '0) ? '0 : ((q_row > nr_m1) ? nr_m1 : q_row);
  assign col_raw = s_div.col_past_first ? (14'(q_col) + 14'd1) : '0;
  assign col_c  = (col_raw > 14'(cpc_m1)) ? cpc_m1 : col_raw[12:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= s_div.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in6_q   <= s_div.in_area;
      chip6_q <= s_div.chip;
      row6_q  <= row_c[12] ? 12'hFFF : row_c[11:0];
      col6_q  <= col_c;
      base6_q <= 17'(s_div.chip) * 17'(cpc_nz);
    end
  end

  // Stage 7: result register.
  logic [17:0] col_sum;
  logic        hit_q;
  logic [11:0] row_q;
  logic [15:0] col_q;
  logic [3:0]  chip_q;

  assign col_sum = 18'(col6_q) + 18'(base6_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= in6_q;
      row_q  <= in6_q ? row6_q : '0;
      col_q  <= !in6_q ? '0 : ((col_sum[17:16] != 2'b0) ? 16'hFFFF : col_sum[15:0]);
      chip_q <= in6_q ? chip6_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_valid_o  = hit_q;
  assign pixel_row_o  = row_q;
  assign pixel_col_o  = col_q;
  assign chip_index_o = chip_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_valid_o |-> pixel_row_o == '0 && pixel_col_o == '0
                                    && chip_index_o == '0)
    else $error("missed hit carries nonzero indices");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_valid_o && cfg.num_rows != '0
      |-> 13'(pixel_row_o) < cfg.num_rows)
    else $error("row beyond the configured row count");

  a_chip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(chip_index_o) < 32'(l2p_pkg::CHIPS_ALONG_Z))
    else $error("chip index beyond the chip count");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_col_o)
                                    && $stable(pixel_row_o))
    else $error("stalled result changed");

endmodule
